// ===== rtl/wsd_pkg.sv =====
// Shared types and constants for the websocket frame deframer.
`default_nettype none
package wsd_pkg;

    localparam int LEN_W = 63;

    typedef enum logic [1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_DATA_HDR = 2'd1,
        EV_CTRL_HDR = 2'd2,
        EV_ERROR    = 2'd3
    } wsd_event_t;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic ERR_NOT_PARSING = 1'b0;
    localparam logic ERR_UNMASKED    = 1'b1;

    localparam logic [3:0] OPC_TEXT   = 4'd1;
    localparam logic [3:0] OPC_BINARY = 4'd2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    localparam logic [3:0] POS_FIRST  = 4'd0;
    localparam logic [3:0] POS_LENGTH = 4'd1;
    localparam logic [3:0] POS_EXT    = 4'd2;
    localparam logic [3:0] POS_KEY_END = 4'd5;

endpackage
`default_nettype wire

// ===== rtl/websocket_frame_deframer.sv =====
// Top level of the websocket frame deframer: header parse and payload unmasking.
`default_nettype none
//  channel | handshake                      | payload
//  input   | in_valid, in_stall (driven)    | operation, data_byte
//  output  | out_valid, out_stall (sampled) | event_res, payload_byte, last, opcode,
//          |                                | payload_length, error_code
//
// One byte is taken every clock unless the input stalls; a byte that yields a result
// has it in the output register in the cycle after the beat.
// The only stall path is the single output register: input stalls while a result
// is held there and the output side stalls.
// Reset returns to header parsing with all frame state cleared; no clearing pass.
module websocket_frame_deframer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      operation,
    input  wire logic [7:0]                data_byte,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output wsd_pkg::wsd_event_t            event_res,
    output logic [7:0]                     payload_byte,
    output logic                           last,
    output logic [3:0]                     opcode,
    output logic [wsd_pkg::LEN_W-1:0]      payload_length,
    output logic                           error_code
);
    import wsd_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CTRL    = 2'd2,
        PH_ERROR   = 2'd3
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [3:0]         hpos_reg, hpos_next;
    logic [3:0]         first_reg, first_next;
    logic [7:0]         len_byte_reg, len_byte_next;
    logic [LEN_W-1:0]   ext_reg, ext_next;
    logic [31:0]        key_reg, key_next;
    logic [1:0]         kidx_reg, kidx_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;

    logic               out_valid_reg, out_valid_next;
    wsd_event_t         event_reg, event_next;
    logic [7:0]         pbyte_reg, pbyte_next;
    logic               last_reg, last_next;
    logic [3:0]         opcode_reg, opcode_next;
    logic [LEN_W-1:0]   plen_reg, plen_next;
    logic               err_reg, err_next;

    logic               accept;
    logic               result;
    logic [3:0]         ext_bytes;
    logic [LEN_W-1:0]   frame_len;
    logic [7:0]         key_byte;
    logic [31:0]        key_shifted;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign out_valid      = out_valid_reg;
    assign event_res      = event_reg;
    assign payload_byte   = pbyte_reg;
    assign last           = last_reg;
    assign opcode         = opcode_reg;
    assign payload_length = plen_reg;
    assign error_code     = err_reg;

    always_comb
    begin
        if (len_byte_reg[6:0] == LEN7_EXT16)
        begin
            ext_bytes = EXT16_BYTES;
        end
        else if (len_byte_reg[6:0] == LEN7_EXT64)
        begin
            ext_bytes = EXT64_BYTES;
        end
        else
        begin
            ext_bytes = 4'd0;
        end
    end

    always_comb
    begin
        if (ext_bytes == EXT16_BYTES)
        begin
            frame_len = {{(LEN_W-16){1'b0}}, ext_reg[15:0]};
        end
        else if (ext_bytes == EXT64_BYTES)
        begin
            frame_len = ext_reg;
        end
        else
        begin
            frame_len = {{(LEN_W-7){1'b0}}, len_byte_reg[6:0]};
        end
    end

    always_comb
    begin
        unique case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign key_shifted = {key_reg[23:0], data_byte};

    always_comb
    begin
        phase_next    = phase_reg;
        hpos_next     = hpos_reg;
        first_next    = first_reg;
        len_byte_next = len_byte_reg;
        ext_next      = ext_reg;
        key_next      = key_reg;
        kidx_next     = kidx_reg;
        remain_next   = remain_reg;

        result      = 1'b0;
        event_next  = event_reg;
        pbyte_next  = 8'd0;
        last_next   = 1'b0;
        opcode_next = 4'd0;
        plen_next   = '0;
        err_next    = 1'b0;

        if (accept)
        begin
            if (operation == OP_RESTART)
            begin
                phase_next    = PH_HEADER;
                hpos_next     = POS_FIRST;
                first_next    = 4'd0;
                len_byte_next = 8'd0;
                ext_next      = '0;
                key_next      = 32'd0;
                kidx_next     = 2'd0;
                remain_next   = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_CTRL, PH_ERROR:
                    begin
                        phase_next = PH_ERROR;
                        result     = 1'b1;
                        event_next = EV_ERROR;
                        err_next   = ERR_NOT_PARSING;
                    end
                    PH_PAYLOAD:
                    begin
                        result      = 1'b1;
                        event_next  = EV_PAYLOAD;
                        pbyte_next  = data_byte ^ key_byte;
                        opcode_next = first_reg;
                        if (remain_reg == {{(LEN_W-1){1'b0}}, 1'b1})
                        begin
                            last_next     = 1'b1;
                            phase_next    = PH_HEADER;
                            hpos_next     = POS_FIRST;
                            first_next    = 4'd0;
                            len_byte_next = 8'd0;
                            ext_next      = '0;
                            key_next      = 32'd0;
                            kidx_next     = 2'd0;
                            remain_next   = '0;
                        end
                        else
                        begin
                            remain_next = remain_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                            kidx_next   = kidx_reg + 2'd1;
                        end
                    end
                    default:
                    begin
                        if (hpos_reg == POS_FIRST)
                        begin
                            first_next = data_byte[3:0];
                            hpos_next  = POS_LENGTH;
                        end
                        else if (hpos_reg == POS_LENGTH)
                        begin
                            len_byte_next = data_byte;
                            ext_next      = '0;
                            key_next      = 32'd0;
                            hpos_next     = POS_EXT;
                        end
                        else if (hpos_reg < POS_EXT + ext_bytes)
                        begin
                            ext_next  = {ext_reg[LEN_W-9:0], data_byte};
                            hpos_next = hpos_reg + 4'd1;
                        end
                        else if (hpos_reg < POS_KEY_END + ext_bytes)
                        begin
                            key_next  = key_shifted;
                            hpos_next = hpos_reg + 4'd1;
                        end
                        else
                        begin
                            key_next  = key_shifted;
                            hpos_next = POS_FIRST;
                            result    = 1'b1;
                            if (!len_byte_reg[7])
                            begin
                                phase_next = PH_ERROR;
                                event_next = EV_ERROR;
                                err_next   = ERR_UNMASKED;
                            end
                            else if (first_reg == OPC_TEXT || first_reg == OPC_BINARY)
                            begin
                                event_next  = EV_DATA_HDR;
                                opcode_next = first_reg;
                                kidx_next   = 2'd0;
                                if (frame_len == '0)
                                begin
                                    last_next     = 1'b1;
                                    phase_next    = PH_HEADER;
                                    first_next    = 4'd0;
                                    len_byte_next = 8'd0;
                                    ext_next      = '0;
                                    key_next      = 32'd0;
                                    remain_next   = '0;
                                end
                                else
                                begin
                                    phase_next  = PH_PAYLOAD;
                                    plen_next   = frame_len;
                                    remain_next = frame_len;
                                end
                            end
                            else
                            begin
                                phase_next  = PH_CTRL;
                                event_next  = EV_CTRL_HDR;
                                opcode_next = first_reg;
                                plen_next   = frame_len;
                            end
                        end
                    end
                endcase
            end
        end

        if (result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hpos_reg      <= POS_FIRST;
            first_reg     <= 4'd0;
            len_byte_reg  <= 8'd0;
            ext_reg       <= '0;
            key_reg       <= 32'd0;
            kidx_reg      <= 2'd0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
            event_reg     <= EV_PAYLOAD;
            pbyte_reg     <= 8'd0;
            last_reg      <= 1'b0;
            opcode_reg    <= 4'd0;
            plen_reg      <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hpos_reg      <= hpos_next;
            first_reg     <= first_next;
            len_byte_reg  <= len_byte_next;
            ext_reg       <= ext_next;
            key_reg       <= key_next;
            kidx_reg      <= kidx_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            if (result)
            begin
                event_reg  <= event_next;
                pbyte_reg  <= pbyte_next;
                last_reg   <= last_next;
                opcode_reg <= opcode_next;
                plen_reg   <= plen_next;
                err_reg    <= err_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== tb/websocket_frame_deframer_checker.sv =====
// Checker for the websocket frame deframer: follows both channels, predicts results and compares.
`timescale 1ns / 1ps

module websocket_frame_deframer_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         operation,
    input  logic [7:0]                   data_byte,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  wsd_pkg::wsd_event_t          event_res,
    input  logic [7:0]                   payload_byte,
    input  logic                         last,
    input  logic [3:0]                   opcode,
    input  logic [wsd_pkg::LEN_W-1:0]    payload_length,
    input  logic                         error_code,
    input  logic                         drain_check,
    output int                           mismatches,
    output int                           pending
);

    import wsd_pkg::*;

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_PAYLOAD,
        ST_CTRL_WAIT,
        ST_ERROR
    } parse_state_t;

    typedef struct packed {
        wsd_event_t       ev;
        logic [7:0]       pbyte;
        logic             fin;
        logic [3:0]       opc;
        logic [LEN_W-1:0] plen;
        logic             err;
    } deframe_result_t;

    deframe_result_t expected_events_q [$];

    parse_state_t parse_state;
    logic [3:0]   hdr_pos;
    logic [7:0]   first_byte;
    logic [7:0]   len_byte;
    logic [63:0]  ext_len;
    logic [31:0]  mask_key;
    logic [63:0]  payload_count;
    logic [63:0]  frame_length;
    logic         drain_checked;

    task automatic report_mismatch(input string msg);
        $display("[%0t] deframer mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void clear_frame_state();
        parse_state   = ST_HEADER;
        hdr_pos       = POS_FIRST;
        first_byte    = '0;
        len_byte      = '0;
        ext_len       = '0;
        mask_key      = '0;
        payload_count = '0;
        frame_length  = '0;
    endfunction

    function automatic void push_result(input wsd_event_t ev, input logic [7:0] pbyte,
                                        input logic fin, input logic [3:0] opc,
                                        input logic [LEN_W-1:0] plen, input logic err);
        deframe_result_t r;
        r.ev    = ev;
        r.pbyte = pbyte;
        r.fin   = fin;
        r.opc   = opc;
        r.plen  = plen;
        r.err   = err;
        expected_events_q.push_back(r);
    endfunction

    task automatic deframe_byte(input logic op, input logic [7:0] b);
        int         n_ext;
        int         pos;
        logic [7:0] key_byte;
        logic [3:0] opc;
        logic       fin;
        if (op == OP_RESTART)
        begin
            clear_frame_state();
            return;
        end
        if (parse_state == ST_CTRL_WAIT || parse_state == ST_ERROR)
        begin
            parse_state = ST_ERROR;
            push_result(EV_ERROR, 8'h00, 1'b0, 4'h0, '0, ERR_NOT_PARSING);
            return;
        end
        if (parse_state == ST_PAYLOAD)
        begin
            key_byte = mask_key[8 * (3 - int'(payload_count[1:0])) +: 8];
            payload_count++;
            fin = (payload_count >= frame_length);
            push_result(EV_PAYLOAD, b ^ key_byte, fin, first_byte[3:0], '0, 1'b0);
            if (fin)
                clear_frame_state();
            return;
        end
        if (hdr_pos == POS_FIRST)
        begin
            first_byte = b;
            hdr_pos    = POS_LENGTH;
            return;
        end
        if (hdr_pos == POS_LENGTH)
        begin
            len_byte = b;
            ext_len  = '0;
            mask_key = '0;
            hdr_pos  = POS_EXT;
            return;
        end
        if (len_byte[6:0] == LEN7_EXT16)
            n_ext = int'(EXT16_BYTES);
        else if (len_byte[6:0] == LEN7_EXT64)
            n_ext = int'(EXT64_BYTES);
        else
            n_ext = 0;
        pos = int'(hdr_pos);
        if (pos < int'(POS_EXT) + n_ext)
        begin
            ext_len = {ext_len[55:0], b};
            hdr_pos = hdr_pos + 4'd1;
            return;
        end
        mask_key = {mask_key[23:0], b};
        if (pos < int'(POS_KEY_END) + n_ext)
        begin
            hdr_pos = hdr_pos + 4'd1;
            return;
        end
        hdr_pos = POS_FIRST;
        if (!len_byte[7])
        begin
            parse_state = ST_ERROR;
            push_result(EV_ERROR, 8'h00, 1'b0, 4'h0, '0, ERR_UNMASKED);
            return;
        end
        if (n_ext == 0)
            frame_length = {57'd0, len_byte[6:0]};
        else if (n_ext == int'(EXT16_BYTES))
            frame_length = {48'd0, ext_len[15:0]};
        else
            frame_length = {1'b0, ext_len[62:0]};
        opc = first_byte[3:0];
        if (opc == OPC_TEXT || opc == OPC_BINARY)
        begin
            payload_count = '0;
            if (frame_length == 0)
            begin
                push_result(EV_DATA_HDR, 8'h00, 1'b1, opc, '0, 1'b0);
                clear_frame_state();
            end
            else
            begin
                parse_state = ST_PAYLOAD;
                push_result(EV_DATA_HDR, 8'h00, 1'b0, opc, frame_length[LEN_W-1:0], 1'b0);
            end
        end
        else
        begin
            parse_state = ST_CTRL_WAIT;
            push_result(EV_CTRL_HDR, 8'h00, 1'b0, opc, frame_length[LEN_W-1:0], 1'b0);
        end
    endtask

    task automatic check_result();
        deframe_result_t want;
        if (expected_events_q.size() == 0)
        begin
            report_mismatch($sformatf("result beat with nothing expected, event %0d", event_res));
            return;
        end
        want = expected_events_q.pop_front();
        if (event_res !== want.ev)
            report_mismatch($sformatf("event_res got %0d expected %0d", event_res, want.ev));
        if (payload_byte !== want.pbyte)
            report_mismatch($sformatf("payload_byte got %02h expected %02h",
                                      payload_byte, want.pbyte));
        if (last !== want.fin)
            report_mismatch($sformatf("last got %0b expected %0b", last, want.fin));
        if (opcode !== want.opc)
            report_mismatch($sformatf("opcode got %0h expected %0h", opcode, want.opc));
        if (payload_length !== want.plen)
            report_mismatch($sformatf("payload_length got %0h expected %0h",
                                      payload_length, want.plen));
        if (error_code !== want.err)
            report_mismatch($sformatf("error_code got %0b expected %0b", error_code, want.err));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame_state();
            expected_events_q.delete();
            mismatches    = 0;
            drain_checked = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                deframe_byte(operation, data_byte);
            if (drain_check && !drain_checked)
            begin
                drain_checked = 1'b1;
                if (expected_events_q.size() != 0)
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              expected_events_q.size()));
            end
        end
        pending = expected_events_q.size();
    end

endmodule

// ===== tb/websocket_frame_deframer_tb.sv =====
// Top of the websocket frame deframer testbench: clock, reset, stimulus, flow control, verdict.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;

    import wsd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic                  operation   = OP_BYTE;
    logic [7:0]            data_byte   = 8'h00;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    wsd_event_t            event_res;
    logic [7:0]            payload_byte;
    logic                  last;
    logic [3:0]            opcode;
    logic [LEN_W-1:0]      payload_length;
    logic                  error_code;
    logic                  drain_check = 1'b0;
    logic                  pressure_req = 1'b0;
    int                    mismatches;
    int                    pending;
    int                    sender_idle_pct = 18;
    int                    recv_idle_pct   = 45;
    int                    beats_sent      = 0;
    int                    cycle_count     = 0;

    websocket_frame_deframer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .payload_byte   (payload_byte),
        .last           (last),
        .opcode         (opcode),
        .payload_length (payload_length),
        .error_code     (error_code)
    );

    websocket_frame_deframer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .payload_byte   (payload_byte),
        .last           (last),
        .opcode         (opcode),
        .payload_length (payload_length),
        .error_code     (error_code),
        .drain_check    (drain_check),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("websocket_frame_deframer_tb failed");
            $finish;
        end
    end

    // The receiver stalls at random, or for a long fixed stretch once when asked.
    initial
    begin : receiver
        int   hold_left;
        logic pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_req && !pressure_done)
            begin
                pressure_done = 1'b1;
                hold_left     = 120;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    task automatic send_beat(input logic op, input logic [7:0] b);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // Sends a frame header, or only its first cut bytes when cut is not negative.
    task automatic send_header(input logic [7:0] first, input logic masked,
                               input logic [6:0] len7, input logic [63:0] ext,
                               input logic [31:0] key, input int cut);
        logic [7:0] hdr [$];
        int         n_ext;
        if (len7 == LEN7_EXT16)
            n_ext = int'(EXT16_BYTES);
        else if (len7 == LEN7_EXT64)
            n_ext = int'(EXT64_BYTES);
        else
            n_ext = 0;
        hdr.push_back(first);
        hdr.push_back({masked, len7});
        for (int i = n_ext - 1; i >= 0; i--)
            hdr.push_back(ext[8 * i +: 8]);
        for (int i = 3; i >= 0; i--)
            hdr.push_back(key[8 * i +: 8]);
        for (int i = 0; i < hdr.size(); i++)
            if (cut < 0 || i < cut)
                send_beat(OP_BYTE, hdr[i]);
    endtask

    task automatic send_random_frame();
        int          pick;
        int          r;
        int          n_payload;
        logic [7:0]  first;
        logic [3:0]  opc;
        logic        masked;
        logic        chop;
        logic [6:0]  len7;
        logic [63:0] ext;
        logic [63:0] flen;
        pick = int'($urandom_range(0, 99));
        if (pick < 5)
        begin
            repeat ($urandom_range(1, 3))
                send_beat(1'($urandom_range(0, 1)), 8'($urandom));
            send_beat(OP_RESTART, 8'($urandom));
            return;
        end
        if (pick < 75)
            opc = 4'($urandom_range(1, 2));
        else
            opc = 4'($urandom_range(0, 15));
        first      = 8'($urandom);
        first[3:0] = opc;
        masked     = ($urandom_range(0, 99) >= 8);
        r          = int'($urandom_range(0, 99));
        ext        = {$urandom, $urandom};
        if (r < 8)
            len7 = 7'($urandom_range(0, 125));
        else if (r < 60)
            len7 = 7'($urandom_range(0, 10));
        else if (r < 80)
            len7 = LEN7_EXT16;
        else
            len7 = LEN7_EXT64;
        if (r >= 64 && r < 80)
            ext[15:0] = 16'($urandom_range(0, 24));
        if (r >= 85)
            ext[62:0] = 63'($urandom_range(0, 24));
        if (len7 == LEN7_EXT16)
            flen = {48'd0, ext[15:0]};
        else if (len7 == LEN7_EXT64)
            flen = {1'b0, ext[62:0]};
        else
            flen = {57'd0, len7};
        chop = (flen > 125) || ($urandom_range(0, 99) < 4);
        if (flen > 125)
            n_payload = int'($urandom_range(0, 6));
        else if (chop && flen > 0)
            n_payload = int'($urandom_range(0, int'(flen) - 1));
        else
            n_payload = int'(flen);
        if ($urandom_range(0, 99) < 3)
        begin
            send_header(first, masked, len7, ext, $urandom, int'($urandom_range(1, 5)));
            send_beat(OP_RESTART, 8'($urandom));
            return;
        end
        send_header(first, masked, len7, ext, $urandom, -1);
        if (masked && (opc == OPC_TEXT || opc == OPC_BINARY))
        begin
            repeat (n_payload)
                send_beat(OP_BYTE, 8'($urandom));
            if (chop)
                send_beat(OP_RESTART, 8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                send_beat(OP_BYTE, 8'($urandom));
            send_beat(OP_RESTART, 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(OP_RESTART, 8'hFF);
        send_header(8'h81, 1'b1, 7'd2, '0, 32'hA5C3_0F96, -1);
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hFF);
        // A zero-length binary frame ends at its header.
        send_header(8'h82, 1'b1, 7'd0, '0, 32'hFFFF_FFFF, -1);
        // A control frame reports its length, then stray bytes are errors until a restart.
        send_header(8'h8F, 1'b1, 7'd125, '0, 32'h0000_0000, -1);
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_RESTART, 8'h00);
        send_header(8'h01, 1'b0, 7'd5, '0, 32'h1234_5678, -1);
        send_beat(OP_RESTART, 8'h00);

        beats_sent = 0;
        while (beats_sent < 450)
            send_random_frame();
        sender_idle_pct = 45;
        recv_idle_pct   = 18;
        while (beats_sent < 900)
            send_random_frame();
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        pressure_req <= 1'b1;
        send_header(8'h82, 1'b1, 7'd60, '0, $urandom, -1);
        repeat (60)
            send_beat(OP_BYTE, 8'($urandom));
        while (beats_sent < 1350)
            send_random_frame();

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        drain_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (mismatches == 0)
            $display("websocket_frame_deframer_tb passed");
        else
            $display("websocket_frame_deframer_tb failed");
        $finish;
    end

endmodule

// ===== websocket_frame_deframer.f =====
rtl/wsd_pkg.sv
rtl/websocket_frame_deframer.sv
tb/websocket_frame_deframer_checker.sv
tb/websocket_frame_deframer_tb.sv
